// ===== hdl/sss_pkg.sv =====
package sss_pkg;

  localparam int MemBytes = 131072;
  localparam int MemAw    = $clog2(MemBytes);
  localparam int AddrW    = 24;
  localparam int ByteW    = 8;
  localparam int BitCntW  = $clog2(ByteW);

  localparam logic [ByteW-1:0] CMD_READ  = 8'h03;
  localparam logic [ByteW-1:0] CMD_WRITE = 8'h02;
  localparam logic [ByteW-1:0] CMD_RDSR  = 8'h05;
  localparam logic [ByteW-1:0] CMD_WRSR  = 8'h01;

  localparam logic [ByteW-1:0] STATUS_WEL = 8'h02;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_READ  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_RDSR  = 3'd3,
    MODE_WRSR  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHIFT,
    ST_EXEC,
    ST_RDWAIT,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/sss_in_if.sv =====
interface sss_in_if;
  import sss_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [ByteW-1:0] mosi_byte;
  logic             select_level;

  modport source (output valid, output opcode, output mosi_byte, output select_level,
                  input ready);
  modport sink (input valid, input opcode, input mosi_byte, input select_level,
                output ready);
endinterface

// ===== hdl/sss_out_if.sv =====
interface sss_out_if;
  import sss_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] miso_byte;

  modport source (output valid, output miso_byte, input ready);
  modport sink (input valid, input miso_byte, output ready);
endinterface

// ===== hdl/spi_sram_slave_core.sv =====
// Channel  Direction  Payload                                Item
// in_ch    sink       opcode, mosi_byte[7:0], select_level   one select change or one SPI byte
// out_ch   source     miso_byte[7:0]                         one answer byte per input item
//
// After reset the block sweeps the whole byte memory (MemBytes, 131072 bytes) to zero, one
// byte per cycle; in_ch.ready stays low until the sweep is done.
// A select change goes from acceptance through execute and done into the output register.
// An SPI byte is first shifted in bit-serially, and a read data byte also waits for memory.
// The next item can be accepted once the answer has entered the output register, even
// while it waits there; a stalled output holds the block only when a second answer is ready.
module spi_sram_slave_core (
  input  logic      clk,
  input  logic      rst,
  sss_in_if.sink    in_ch,
  sss_out_if.source out_ch
);
  import sss_pkg::*;

  state_t state, state_next;

  // Item capture. The byte register rotates one bit per cycle while shifting, so that it
  // holds the whole byte again when execution starts.
  logic             item_op;
  logic             item_sel;
  logic [ByteW-1:0] rx;
  logic [BitCntW-1:0] bit_cnt;

  mode_t            mode;
  logic [1:0]       phase_count;
  logic [AddrW-1:0] address;
  logic             write_enable;

  logic [MemAw-1:0] clr_cnt;
  logic [ByteW-1:0] res;
  logic             out_valid;
  logic [ByteW-1:0] out_byte;

  // Memory port controls.
  logic             mem_wr_en;
  logic [MemAw-1:0] mem_wr_addr;
  logic [ByteW-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [ByteW-1:0] mem_rd_data;

  logic in_acc;
  logic addr_phase;
  logic out_free;

  assign in_acc     = in_ch.valid && in_ch.ready;
  // Address bytes are shifted straight into the address register, MSB first.
  assign addr_phase = ((mode == MODE_READ) || (mode == MODE_WRITE)) && (phase_count != 2'd3);
  assign out_free   = !out_valid || out_ch.ready;

  assign out_ch.valid     = out_valid;
  assign out_ch.miso_byte = out_byte;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == MemAw'(MemBytes - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_next = in_ch.opcode ? ST_EXEC : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (bit_cnt == BitCntW'(ByteW - 1)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!item_op && (mode == MODE_READ) && (phase_count == 2'd3)) begin
          state_next = ST_RDWAIT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RDWAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine: handshake and memory port.
  always_comb begin
    in_ch.ready = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = address[MemAw-1:0];
    mem_wr_data = rx;
    mem_rd_en   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt;
        mem_wr_data = '0;
      end
      ST_IDLE: in_ch.ready = 1'b1;
      ST_EXEC: begin
        if (!item_op && (phase_count == 2'd3)) begin
          mem_rd_en = (mode == MODE_READ);
          mem_wr_en = (mode == MODE_WRITE) && write_enable;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      mode         <= MODE_IDLE;
      phase_count  <= 2'd0;
      address      <= '0;
      write_enable <= 1'b0;
      clr_cnt      <= '0;
      bit_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      // A new answer enters the output register as soon as the old one has left it.
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + MemAw'(1);
        ST_IDLE: begin
          if (in_acc) begin
            item_op  <= in_ch.opcode;
            item_sel <= in_ch.select_level;
            rx       <= in_ch.mosi_byte;
            bit_cnt  <= '0;
          end
        end
        ST_SHIFT: begin
          rx      <= {rx[ByteW-2:0], rx[ByteW-1]};
          bit_cnt <= bit_cnt + BitCntW'(1);
          if (addr_phase) begin
            // The first address byte starts from a cleared register.
            if ((phase_count == 2'd0) && (bit_cnt == '0)) begin
              address <= {{(AddrW-1){1'b0}}, rx[ByteW-1]};
            end else begin
              address <= {address[AddrW-2:0], rx[ByteW-1]};
            end
          end
        end
        ST_EXEC: begin
          // Only a status read answers with something other than zero here.
          res <= (!item_op && (mode == MODE_RDSR) && write_enable) ? STATUS_WEL : '0;
          if (item_op) begin
            if (!item_sel) begin
              mode        <= MODE_IDLE;
              phase_count <= 2'd0;
            end
          end else begin
            unique case (mode)
              MODE_IDLE: begin
                phase_count <= 2'd0;
                unique case (rx)
                  CMD_READ:  mode <= MODE_READ;
                  CMD_WRITE: mode <= MODE_WRITE;
                  CMD_RDSR:  mode <= MODE_RDSR;
                  CMD_WRSR:  mode <= MODE_WRSR;
                  default:   mode <= MODE_IDLE;
                endcase
              end
              MODE_READ: begin
                if (phase_count != 2'd3) begin
                  phase_count <= phase_count + 2'd1;
                end else begin
                  address <= address + AddrW'(1);
                end
              end
              MODE_WRITE: begin
                if (phase_count != 2'd3) begin
                  phase_count <= phase_count + 2'd1;
                end else if (write_enable) begin
                  address <= address + AddrW'(1);
                end
              end
              MODE_RDSR: begin
                // The status answer is set above; the mode stays until deselect.
              end
              MODE_WRSR: begin
                write_enable <= rx[1];
                mode         <= MODE_IDLE;
              end
              default: mode <= MODE_IDLE;
            endcase
          end
        end
        ST_RDWAIT: res <= mem_rd_data;
        ST_DONE: begin
          if (out_free) begin
            out_byte <= res;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Byte memory; its low address bits form the memory index.
  sss_ram #(
    .WIDTH (ByteW),
    .DEPTH (MemBytes)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (address[MemAw-1:0]),
    .rd_data (mem_rd_data)
  );

endmodule

// ===== hdl/sss_ram.sv =====
module sss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sss_checker.sv =====
module sss_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] miso_byte
);

  // The memory sweep keeps the input closed right after reset.
  a_closed_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready right after reset");

  // One item at a time: an accepted item closes the input on the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after an accepted item");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_byte_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(miso_byte))
    else $error("output byte changed while stalled");

endmodule

bind spi_sram_slave_core sss_checker u_sss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .miso_byte (out_ch.miso_byte)
);

// ===== verif/spi_sram_slave_core_tb.sv =====
module spi_sram_slave_core_tb;
  import sss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The clock starts low so that no edge is seen at time zero.
  bit clk;
  logic rst;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sss_in_if in_ch ();
  sss_out_if out_ch ();

  spi_sram_slave_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Chance, in percent, that the sender leaves a cycle empty before an item, and that the
  // receiver keeps ready low in a cycle. The test tasks set both for each phase of the run.
  int tx_idle_pct;
  int rx_idle_pct;

  // A request for a long output stall. The receiver process takes it over and counts it
  // down one cycle at a time, while the sender keeps offering items.
  int rx_hold_req;
  int rx_hold_left;

  int items_sent;
  int mismatch_count;

  // Answer bytes that the block still owes, oldest first.
  logic [ByteW-1:0] expected_miso[$];

  // Private copy of the serial SRAM state. It is advanced once for every accepted item,
  // in the order in which the block accepts them.
  mode_t            sram_mode;
  logic [1:0]       sram_phase;
  logic [AddrW-1:0] sram_addr;
  logic             sram_wel;
  logic [ByteW-1:0] sram_image [MemBytes];

  // Computes the answer byte for one item and updates the SRAM copy. The address phase
  // counter counts the three address bytes and then stays at three, so data bytes go
  // straight to or from memory. Memory is indexed by the 24-bit address modulo its size.
  function automatic logic [ByteW-1:0] predict_miso(input logic op, input logic [ByteW-1:0] b,
                                                    input logic sel);
    logic [ByteW-1:0] answer;
    answer = '0;
    if (op) begin
      // Raising select changes nothing; dropping it ends whatever command was running.
      if (!sel) begin
        sram_mode  = MODE_IDLE;
        sram_phase = '0;
      end
    end else begin
      // Bytes are handled the same way whether or not the chip is selected.
      case (sram_mode)
        MODE_IDLE: begin
          sram_phase = '0;
          case (b)
            CMD_READ:  sram_mode = MODE_READ;
            CMD_WRITE: sram_mode = MODE_WRITE;
            CMD_RDSR:  sram_mode = MODE_RDSR;
            CMD_WRSR:  sram_mode = MODE_WRSR;
            default:   sram_mode = MODE_IDLE;
          endcase
        end
        MODE_READ: begin
          if (sram_phase < 2'd3) begin
            case (sram_phase)
              2'd0:    sram_addr = {b, 16'h0000};
              2'd1:    sram_addr = sram_addr | {8'h00, b, 8'h00};
              default: sram_addr = sram_addr | {16'h0000, b};
            endcase
            sram_phase = sram_phase + 2'd1;
          end else begin
            answer    = sram_image[sram_addr % MemBytes];
            sram_addr = sram_addr + 1'b1;
          end
        end
        MODE_RDSR: answer = sram_wel ? STATUS_WEL : '0;
        MODE_WRSR: begin
          sram_wel  = b[1];
          sram_mode = MODE_IDLE;
        end
        MODE_WRITE: begin
          if (sram_phase < 2'd3) begin
            case (sram_phase)
              2'd0:    sram_addr = {b, 16'h0000};
              2'd1:    sram_addr = sram_addr | {8'h00, b, 8'h00};
              default: sram_addr = sram_addr | {16'h0000, b};
            endcase
            sram_phase = sram_phase + 2'd1;
          end else if (sram_wel) begin
            // With write enable clear the byte is dropped and the address holds.
            sram_image[sram_addr % MemBytes] = b;
            sram_addr = sram_addr + 1'b1;
          end
        end
        default: sram_mode = MODE_IDLE;
      endcase
    end
    return answer;
  endfunction

  // Offers one item, with random empty cycles in front of it. Called at a falling edge and
  // returns at a falling edge. Valid is left high on return, so back-to-back items keep it
  // high; the next call or a pause lowers it, never twice in one step.
  task automatic send_item(input logic op, input logic [ByteW-1:0] b, input logic sel);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.mosi_byte    <= b;
    in_ch.select_level <= sel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_miso.push_back(predict_miso(op, b, sel));
    items_sent++;
    @(negedge clk);
  endtask

  // Unused payload fields carry random values so that every bit toggles.
  task automatic spi_xfer(input logic [ByteW-1:0] b);
    send_item(1'b0, b, 1'($urandom));
  endtask

  task automatic chip_select(input logic level);
    send_item(1'b1, 8'($urandom), level);
  endtask

  task automatic send_address(input logic [AddrW-1:0] a);
    spi_xfer(a[23:16]);
    spi_xfer(a[15:8]);
    spi_xfer(a[7:0]);
  endtask

  // Stops offering items and waits until the block has returned every answer owed.
  task automatic drain_answers();
    in_ch.valid <= 1'b0;
    while (expected_miso.size() != 0) @(negedge clk);
  endtask

  // Addresses mostly fall into small windows, so that reads find earlier writes. The
  // upper bits are random, which exercises the aliasing of the memory index, and one
  // window straddles the end of the memory.
  function automatic logic [AddrW-1:0] pick_address();
    logic [16:0] low;
    case ($urandom_range(0, 3))
      0:       low = 17'($urandom_range(0, 63));
      1:       low = 17'h1ffe0 + 17'($urandom_range(0, 63));
      2:       low = 17'h08000 + 17'($urandom_range(0, 63));
      default: return AddrW'($urandom);
    endcase
    return {7'($urandom), low};
  endfunction

  // A complete write command with random data. Select is sometimes skipped, since bytes
  // are processed the same way while the chip is deselected.
  task automatic mem_write_burst(input logic [AddrW-1:0] a, input int len);
    if ($urandom_range(0, 9) != 0) chip_select(1'b1);
    spi_xfer(CMD_WRITE);
    send_address(a);
    repeat (len) spi_xfer(8'($urandom));
    chip_select(1'b0);
  endtask

  task automatic mem_read_burst(input logic [AddrW-1:0] a, input int len);
    if ($urandom_range(0, 9) != 0) chip_select(1'b1);
    spi_xfer(CMD_READ);
    send_address(a);
    repeat (len) spi_xfer(8'($urandom));
    chip_select(1'b0);
  endtask

  // Hand-picked items: status write and read, a write and a read that wrap the 24-bit
  // address and the memory index, an unknown command, and a write while disabled.
  task automatic test_directed();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    chip_select(1'b1);
    spi_xfer(CMD_WRSR);
    spi_xfer(8'hff);
    spi_xfer(CMD_RDSR);
    spi_xfer(8'h00);
    spi_xfer(8'hff);
    chip_select(1'b0);
    // The data phase starts at the last address and rolls over to zero.
    spi_xfer(CMD_WRITE);
    send_address(24'hffffff);
    spi_xfer(8'h00);
    spi_xfer(8'hff);
    chip_select(1'b0);
    spi_xfer(CMD_READ);
    send_address(24'hffffff);
    spi_xfer(8'h55);
    spi_xfer(8'haa);
    chip_select(1'b0);
    // An unknown command leaves the block idle, so the next byte is a command again.
    spi_xfer(8'hff);
    spi_xfer(CMD_WRSR);
    spi_xfer(8'h00);
    spi_xfer(CMD_WRITE);
    send_address(24'h000000);
    spi_xfer(8'h5a);
    chip_select(1'b0);
  endtask

  // Mostly well-formed commands with random content; the rest are commands cut short by a
  // deselect and plain noise.
  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    int stop_at;
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        mem_write_burst(pick_address(), $urandom_range(1, 8));
      end else if (pick < 65) begin
        mem_read_burst(pick_address(), $urandom_range(1, 8));
      end else if (pick < 73) begin
        chip_select(1'b1);
        spi_xfer(CMD_RDSR);
        repeat ($urandom_range(1, 3)) spi_xfer(8'($urandom));
        chip_select(1'b0);
      end else if (pick < 85) begin
        // Write enable is set more often than cleared so that most writes land.
        chip_select(1'b1);
        spi_xfer(CMD_WRSR);
        spi_xfer(8'($urandom) | (($urandom_range(0, 9) < 7) ? 8'h02 : 8'h00));
        chip_select(1'b0);
      end else if (pick < 93) begin
        chip_select(1'b1);
        spi_xfer($urandom_range(0, 1) ? CMD_READ : CMD_WRITE);
        repeat ($urandom_range(0, 2)) spi_xfer(8'($urandom));
        chip_select(1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) send_item(1'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // The receiver stops for a long stretch while items keep coming, so the output register
  // fills, the block stalls its input, and everything must come out intact afterwards.
  task automatic test_output_backpressure();
    logic [AddrW-1:0] a;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    a = pick_address();
    chip_select(1'b1);
    spi_xfer(CMD_WRSR);
    spi_xfer(8'h02);
    rx_hold_req = 400;
    mem_write_burst(a, 12);
    mem_read_burst(a, 12);
  endtask

  // The sender goes quiet until the block has answered everything, then reads back.
  task automatic test_sender_pause();
    logic [AddrW-1:0] a;
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    a = pick_address();
    mem_write_burst(a, 6);
    drain_answers();
    @(negedge clk);
    mem_read_burst(a, 6);
    drain_answers();
    @(negedge clk);
  endtask

  // Receiver: ready changes at the falling edge, either random or held low during a
  // requested stall.
  always @(negedge clk) begin
    if (rx_hold_left == 0 && rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Every answer taken at a rising edge is compared with the oldest one owed.
  always @(posedge clk) begin : check_answers
    logic [ByteW-1:0] want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_miso.size() == 0) begin
        $error("miso_byte: no answer expected, actual 0x%02h", out_ch.miso_byte);
        mismatch_count++;
      end else begin
        want = expected_miso.pop_front();
        if (out_ch.miso_byte !== want) begin
          $error("miso_byte mismatch: expected 0x%02h, actual 0x%02h", want,
                 out_ch.miso_byte);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int guard;
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = 1'b0;
    in_ch.mosi_byte    = '0;
    in_ch.select_level = 1'b0;
    out_ch.ready       = 1'b0;
    tx_idle_pct        = 0;
    rx_idle_pct        = 0;
    rx_hold_req        = 0;
    rx_hold_left       = 0;
    items_sent         = 0;
    mismatch_count     = 0;
    sram_mode          = MODE_IDLE;
    sram_phase         = '0;
    sram_addr          = '0;
    sram_wel           = 1'b0;
    foreach (sram_image[i]) sram_image[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // After reset the block clears its memory before it takes the first item; the sender
    // simply waits for ready.
    test_directed();
    test_random_traffic(490, 34, 56);
    test_random_traffic(490, 56, 34);
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic(490, 0, 0);

    // Wait for the last answers, then a few more cycles to catch anything extra.
    in_ch.valid <= 1'b0;
    guard = 0;
    while (expected_miso.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (expected_miso.size() != 0) begin
      $error("miso_byte: %0d expected answers never arrived", expected_miso.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard limit: the memory clear plus the whole run take well under a millisecond.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
